### design/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// Widths, constants and types shared by the UTF-8 stream decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int LEN_W  = 3;
    localparam int CNT_W  = 16;
    localparam int PV_W   = 18;
    localparam int SEEN_W = 2;

    localparam logic [CP_W-1:0]  REPL_CP   = 21'h00FFFD;
    localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

    localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    // One decoded result word.
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] byte_length;
        logic             end_of_text;
        logic [CNT_W-1:0] char_count;
        logic             last_result;
    } t_result;

endpackage

`default_nettype wire

### design/u8sd_if.sv
// ----------------------------------------------------------------------------
// u8sd_if
// Valid/ready channels for the byte input and the decoded result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8sd_byte_if;
    logic                        valid;
    logic                        ready;
    logic [u8sd_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface u8sd_result_if;
    logic                         valid;
    logic                         ready;
    logic [u8sd_pkg::CP_W-1:0]    code_point;
    logic [u8sd_pkg::LEN_W-1:0]   byte_length;
    logic                         end_of_text;
    logic [u8sd_pkg::CNT_W-1:0]   char_count;
    logic                         last_result;

    modport source (output valid, output code_point, output byte_length,
                    output end_of_text, output char_count, output last_result,
                    input ready);
    modport sink   (input valid, input code_point, input byte_length,
                    input end_of_text, input char_count, input last_result,
                    output ready);
endinterface

`default_nettype wire

### design/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Lenient UTF-8 decoder taking one byte per word and giving code points.
// ----------------------------------------------------------------------------
// A byte is decoded in the cycle it is accepted; its results wait in a small
// work register and leave one per cycle, while the sink takes them, through
// the output register. A byte that gives no result or one result does not
// hold the input, and the decoder takes a byte every cycle while the sink
// keeps up. A byte that breaks an open sequence holding k bytes gives k
// replacements plus its own result if it has one, up to four words, and the
// input is held until the last of them is loaded into the single output
// register. A zero byte ends the text and gives a word carrying the
// saturating code point count, after which counting starts again from zero.
`default_nettype none

module utf8_stream_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    u8sd_byte_if.sink       i_byte,
    u8sd_result_if.source   o_result
);

    // Sequence state.
    logic [u8sd_pkg::PV_W-1:0]   r_pv,  n_pv;
    logic [u8sd_pkg::LEN_W-1:0]  r_el,  n_el;
    logic [u8sd_pkg::SEEN_W-1:0] r_bs,  n_bs;
    logic [u8sd_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    // Work register: replacements still to send, then an optional final word.
    logic [u8sd_pkg::SEEN_W-1:0] r_rep_left, n_rep_left;
    logic                        r_fin_valid, n_fin_valid;
    u8sd_pkg::t_result           r_fin, n_fin;

    // Output register.
    logic                        r_out_valid;
    u8sd_pkg::t_result           r_out, n_out;

    logic                        accept;
    logic                        work_has;
    logic                        work_last;
    logic                        load;
    logic                        in_cont;
    logic [u8sd_pkg::CP_W-1:0]   cont_value;
    logic [u8sd_pkg::CNT_W:0]    sum_all;
    logic [u8sd_pkg::CNT_W:0]    sum_rep;
    logic [u8sd_pkg::CNT_W-1:0]  sat_all;
    logic [u8sd_pkg::CNT_W-1:0]  sat_rep;
    logic [u8sd_pkg::SEEN_W-1:0] d_rep;
    logic                        d_fin_valid;
    logic                        d_end;
    u8sd_pkg::t_result           d_fin;

    assign work_has  = (r_rep_left != '0) || r_fin_valid;
    // The word leaving the work register now is the last one of its byte.
    assign work_last = ((r_rep_left == '0) && r_fin_valid)
                    || ((r_rep_left == 2'd1) && !r_fin_valid);
    assign load      = work_has && (!r_out_valid || o_result.ready);
    assign i_byte.ready = !work_has || (load && work_last);
    assign accept    = i_byte.valid && i_byte.ready;

    assign in_cont    = (i_byte.data_byte[7:6] == 2'b10);
    assign cont_value = {r_pv[14:0], i_byte.data_byte[5:0]};

    // Decode of the incoming byte against the current sequence state.
    always_comb begin
        n_pv        = r_pv;
        n_el        = r_el;
        n_bs        = r_bs;
        d_rep       = '0;
        d_fin_valid = 1'b0;
        d_end       = 1'b0;
        d_fin       = '0;
        d_fin.last_result = 1'b1;

        if ((r_el != u8sd_pkg::LEN_NONE) && in_cont) begin
            if (({1'b0, r_bs} + 3'd1) >= r_el) begin
                d_fin_valid       = 1'b1;
                d_fin.code_point  = cont_value;
                d_fin.byte_length = r_el;
                n_pv = '0;
                n_el = u8sd_pkg::LEN_NONE;
                n_bs = '0;
            end else begin
                n_pv = {r_pv[11:0], i_byte.data_byte[5:0]};
                n_bs = r_bs + 2'd1;
            end
        end else begin
            // A broken sequence gives one replacement per byte held.
            if (r_el != u8sd_pkg::LEN_NONE) begin
                d_rep = r_bs;
            end
            n_pv = '0;
            n_el = u8sd_pkg::LEN_NONE;
            n_bs = '0;
            priority if (i_byte.data_byte == '0) begin
                d_fin_valid       = 1'b1;
                d_end             = 1'b1;
                d_fin.end_of_text = 1'b1;
                d_fin.byte_length = u8sd_pkg::LEN_NONE;
            end else if (!i_byte.data_byte[7]) begin
                d_fin_valid       = 1'b1;
                d_fin.code_point  = {13'd0, i_byte.data_byte};
                d_fin.byte_length = u8sd_pkg::LEN_ONE;
            end else if (i_byte.data_byte[7:5] == 3'b110) begin
                n_pv = {13'd0, i_byte.data_byte[4:0]};
                n_el = u8sd_pkg::LEN_TWO;
                n_bs = 2'd1;
            end else if (i_byte.data_byte[7:4] == 4'b1110) begin
                n_pv = {14'd0, i_byte.data_byte[3:0]};
                n_el = u8sd_pkg::LEN_THREE;
                n_bs = 2'd1;
            end else if (i_byte.data_byte[7:3] == 5'b11110) begin
                n_pv = {15'd0, i_byte.data_byte[2:0]};
                n_el = u8sd_pkg::LEN_FOUR;
                n_bs = 2'd1;
            end else begin
                d_fin_valid       = 1'b1;
                d_fin.code_point  = u8sd_pkg::REPL_CP;
                d_fin.byte_length = u8sd_pkg::LEN_ONE;
            end
        end

        sum_rep = {1'b0, r_cnt} + {15'd0, d_rep};
        sum_all = sum_rep + {16'd0, d_fin_valid && !d_end};
        sat_rep = sum_rep[u8sd_pkg::CNT_W] ? u8sd_pkg::CNT_MAX
                                           : sum_rep[u8sd_pkg::CNT_W-1:0];
        sat_all = sum_all[u8sd_pkg::CNT_W] ? u8sd_pkg::CNT_MAX
                                           : sum_all[u8sd_pkg::CNT_W-1:0];
        if (d_end) begin
            d_fin.char_count = sat_rep;
            n_cnt = '0;
        end else begin
            n_cnt = sat_all;
        end
    end

    // Work register and output register next values.
    always_comb begin
        n_rep_left  = r_rep_left;
        n_fin_valid = r_fin_valid;
        n_fin       = r_fin;
        n_out       = r_out;

        if (load) begin
            if (r_rep_left != '0) begin
                n_out.code_point  = u8sd_pkg::REPL_CP;
                n_out.byte_length = u8sd_pkg::LEN_ONE;
                n_out.end_of_text = 1'b0;
                n_out.char_count  = '0;
                n_out.last_result = work_last;
                n_rep_left        = r_rep_left - 2'd1;
            end else begin
                n_out       = r_fin;
                n_fin_valid = 1'b0;
            end
        end

        if (accept) begin
            n_rep_left  = d_rep;
            n_fin_valid = d_fin_valid;
            n_fin       = d_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv        <= '0;
            r_el        <= u8sd_pkg::LEN_NONE;
            r_bs        <= '0;
            r_cnt       <= '0;
            r_rep_left  <= '0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pv  <= n_pv;
                r_el  <= n_el;
                r_bs  <= n_bs;
                r_cnt <= n_cnt;
            end
            r_rep_left  <= n_rep_left;
            r_fin_valid <= n_fin_valid;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin <= n_fin;
        r_out <= n_out;
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.code_point  = r_out.code_point;
    assign o_result.byte_length = r_out.byte_length;
    assign o_result.end_of_text = r_out.end_of_text;
    assign o_result.char_count  = r_out.char_count;
    assign o_result.last_result = r_out.last_result;

endmodule

`default_nettype wire
